/* rtl/core/utf8_to_code_point_decoder_top_defines.svh */
// assertion macros for the utf-8 decoder block
// used by utf8_to_code_point_decoder_top only
`ifndef UTF8_TO_CODE_POINT_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define UTFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UTFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/utfd_pkg.sv */
// shared types, constants and helpers of the utf-8 decoder
// no dependencies
package utfd_pkg;

   localparam int unsigned CP_WIDTH   = 31;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned RAW_SLOTS  = 5;
   localparam int unsigned CNT_WIDTH  = 3;

   localparam logic [BYTE_WIDTH-1:0] CONT_TAG = 8'h80;
   localparam logic [1:0]            CONT_TOP = 2'b10;

   localparam logic [BYTE_WIDTH-1:0] MASK_LEN2 = 8'h1F;
   localparam logic [BYTE_WIDTH-1:0] MASK_LEN3 = 8'h0F;
   localparam logic [BYTE_WIDTH-1:0] MASK_LEN4 = 8'h07;
   localparam logic [BYTE_WIDTH-1:0] MASK_LEN5 = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] MASK_LEN6 = 8'h01;

   localparam logic [CNT_WIDTH-1:0] LEN_NONE = 3'd0;
   localparam logic [CNT_WIDTH-1:0] LEN_2    = 3'd2;
   localparam logic [CNT_WIDTH-1:0] LEN_3    = 3'd3;
   localparam logic [CNT_WIDTH-1:0] LEN_4    = 3'd4;
   localparam logic [CNT_WIDTH-1:0] LEN_5    = 3'd5;
   localparam logic [CNT_WIDTH-1:0] LEN_6    = 3'd6;

   // results caused by one input byte
   typedef struct packed {
      logic [CNT_WIDTH-1:0]                  count;
      logic                                  eos;
      logic [CP_WIDTH-1:0]                   first;
      logic [RAW_SLOTS-1:0][BYTE_WIDTH-1:0]  raw;
   } run_type;

   // rebuild a gathered continuation byte, pos counts groups from the low end
   function automatic logic [BYTE_WIDTH-1:0] cont_byte(input logic [23:0] acc,
                                                       input logic [1:0]  pos);
      logic [5:0] bits;
      case (pos)
         2'd0:    bits = acc[5:0];
         2'd1:    bits = acc[11:6];
         2'd2:    bits = acc[17:12];
         default: bits = acc[23:18];
      endcase
      return CONT_TAG | {2'b00, bits};
   endfunction

endpackage

/* rtl/core/utfd_req_if.sv */
// input channel of the utf-8 decoder: one string byte per word
// no dependencies
interface utfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

/* rtl/core/utfd_rsp_if.sv */
// result channel of the utf-8 decoder: one code point per word
// no dependencies
interface utfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] code_point;
   logic        last_in_run;
   logic        string_done;

   modport source (output valid, output code_point, output last_in_run,
                   output string_done, input ready);
   modport sink (input valid, input code_point, input last_in_run,
                 input string_done, output ready);
endinterface

/* rtl/core/utf8_to_code_point_decoder_top.sv */
// utf-8 decoder top: input register, decode, result register
// a byte's first result passes the input register, then the result register
// throughput: one byte per cycle while results are taken; a byte causing results
// holds the next such byte till the result register, one word per cycle, ends it
// reset: synchronous, clears the input register, sequence state and result register
`include "utf8_to_code_point_decoder_top_defines.svh"
module utf8_to_code_point_decoder_top (
   input  logic       clock,
   input  logic       reset,
   utfd_req_if.sink   req_ch,
   utfd_rsp_if.source rsp_ch
);

   logic              in_v_ff;
   logic [7:0]        in_byte_ff;
   logic              in_eos_ff;
   logic              adv;
   logic              load;
   logic              can_load;
   utfd_pkg::run_type run;

   assign adv           = in_v_ff && ((run.count == 3'd0) || can_load);
   assign load          = adv && (run.count != 3'd0);
   assign req_ch.ready  = !in_v_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
         in_eos_ff  <= req_ch.end_of_string;
      end
   end

   utfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .data_byte (in_byte_ff),
      .eos       (in_eos_ff),
      .run       (run)
   );

   utfd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .run_in   (run),
      .load     (load),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

   `UTFD_ASSERT_NOW(a_run_fits, clock, reset, adv, run.count <= 3'd6, "run longer than six words")
   `UTFD_ASSERT_NOW(a_load_room, clock, reset, load, can_load, "run loaded over a busy result register")
   `UTFD_ASSERT_NEXT(a_in_hold, clock, reset, in_v_ff && !adv, in_v_ff && $stable(in_byte_ff), "held byte lost")
   `UTFD_ASSERT_NOW(a_done_last, clock, reset, rsp_ch.valid && rsp_ch.string_done, rsp_ch.last_in_run, "string end before run end")

endmodule

/* rtl/core/utfd_core.sv */
// sequence state and single-pass decode of one byte into a run of results
// depends on utfd_pkg
module utfd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [7:0]          data_byte,
   input  logic                eos,
   output utfd_pkg::run_type   run
);

   logic [7:0]  lead_ff, lead_in;
   logic [2:0]  exp_ff, exp_in;
   logic [2:0]  gcnt_ff, gcnt_in;
   logic [30:0] acc_ff, acc_in;

   logic        open_seq;
   logic        is_cont;
   logic        complete;
   logic        extra;
   logic [2:0]  flen;
   logic [7:0]  fmask;
   logic [2:0]  g_cat;
   logic [30:0] acc_cat;
   logic [2:0]  src_g;
   logic [30:0] src_acc;
   logic [2:0]  pos;

   always_comb begin
      unique case (data_byte) inside
         [8'hC0:8'hDF]: begin flen = utfd_pkg::LEN_2;    fmask = utfd_pkg::MASK_LEN2; end
         [8'hE0:8'hEF]: begin flen = utfd_pkg::LEN_3;    fmask = utfd_pkg::MASK_LEN3; end
         [8'hF0:8'hF7]: begin flen = utfd_pkg::LEN_4;    fmask = utfd_pkg::MASK_LEN4; end
         [8'hF8:8'hFB]: begin flen = utfd_pkg::LEN_5;    fmask = utfd_pkg::MASK_LEN5; end
         [8'hFC:8'hFD]: begin flen = utfd_pkg::LEN_6;    fmask = utfd_pkg::MASK_LEN6; end
         default:       begin flen = utfd_pkg::LEN_NONE; fmask = 8'h00;               end
      endcase
   end

   assign open_seq = (exp_ff >= utfd_pkg::LEN_2);
   assign is_cont  = (data_byte[7:6] == utfd_pkg::CONT_TOP);
   assign g_cat    = gcnt_ff + 3'd1;
   assign acc_cat  = {acc_ff[24:0], data_byte[5:0]};
   assign complete = (({1'b0, g_cat} + 4'd1) >= {1'b0, exp_ff});
   assign extra    = (flen == utfd_pkg::LEN_NONE) || eos;

   always_comb begin
      lead_in   = lead_ff;
      exp_in    = exp_ff;
      gcnt_in   = gcnt_ff;
      acc_in    = acc_ff;
      src_g     = 3'd0;
      src_acc   = acc_ff;
      run.count = 3'd0;
      run.eos   = eos;
      run.first = {23'd0, lead_ff};
      pos       = 3'd0;

      if (open_seq && is_cont) begin
         if (complete) begin
            run.first = acc_cat;
            run.count = 3'd1;
            lead_in   = 8'h00;
            exp_in    = utfd_pkg::LEN_NONE;
            gcnt_in   = 3'd0;
            acc_in    = 31'd0;
         end else if (eos) begin
            src_g     = g_cat;
            src_acc   = acc_cat;
            run.count = 3'd1 + g_cat;
            lead_in   = 8'h00;
            exp_in    = utfd_pkg::LEN_NONE;
            gcnt_in   = 3'd0;
            acc_in    = 31'd0;
         end else begin
            gcnt_in = g_cat;
            acc_in  = acc_cat;
         end
      end else begin
         if (open_seq) begin
            src_g     = gcnt_ff;
            run.count = 3'd1 + gcnt_ff + {2'b00, extra};
         end else begin
            run.first = {23'd0, data_byte};
            run.count = {2'b00, extra};
         end
         if (extra) begin
            lead_in = 8'h00;
            exp_in  = utfd_pkg::LEN_NONE;
            gcnt_in = 3'd0;
            acc_in  = 31'd0;
         end else begin
            lead_in = data_byte;
            exp_in  = flen;
            gcnt_in = 3'd0;
            acc_in  = {23'd0, data_byte & fmask};
         end
      end

      for (int j = 0; j < utfd_pkg::RAW_SLOTS; j++) begin
         pos = src_g - 3'd1 - 3'(j);
         if (3'(j) < src_g) begin
            run.raw[j] = utfd_pkg::cont_byte(src_acc[23:0], pos[1:0]);
         end else begin
            run.raw[j] = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 8'h00;
         exp_ff  <= utfd_pkg::LEN_NONE;
         gcnt_ff <= 3'd0;
         acc_ff  <= 31'd0;
      end else if (adv) begin
         lead_ff <= lead_in;
         exp_ff  <= exp_in;
         gcnt_ff <= gcnt_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

/* rtl/core/utfd_seq.sv */
// result register: holds one run and hands it out one word per cycle while words are taken
// depends on utfd_pkg and utfd_rsp_if
module utfd_seq (
   input  logic               clock,
   input  logic               reset,
   input  utfd_pkg::run_type  run_in,
   input  logic               load,
   output logic               can_load,
   utfd_rsp_if.source         rsp
);

   logic                                                 valid_ff;
   logic [utfd_pkg::CNT_WIDTH-1:0]                       count_ff;
   logic                                                 eos_ff;
   logic [utfd_pkg::CP_WIDTH-1:0]                        first_ff;
   logic [utfd_pkg::RAW_SLOTS-1:0][utfd_pkg::BYTE_WIDTH-1:0] raw_ff;

   logic pop;
   logic last;

   assign pop      = valid_ff && rsp.ready;
   assign last     = (count_ff == 3'd1);
   assign can_load = !valid_ff || (pop && last);

   assign rsp.valid       = valid_ff;
   assign rsp.code_point  = first_ff;
   assign rsp.last_in_run = last;
   assign rsp.string_done = eos_ff && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= 3'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         count_ff <= run_in.count;
      end else if (pop) begin
         valid_ff <= !last;
         count_ff <= count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         eos_ff   <= run_in.eos;
         first_ff <= run_in.first;
         raw_ff   <= run_in.raw;
      end else if (pop) begin
         first_ff <= {23'd0, raw_ff[0]};
         raw_ff   <= raw_ff >> utfd_pkg::BYTE_WIDTH;
      end
   end

endmodule
